// ----- rtl/core/dpjs_pkg.sv -----
`default_nettype none

package dpjs_pkg;

   localparam int PEND_DEPTH = 16;
   localparam int ACT_DEPTH = 4;
   localparam int WORKER_CAP = 4;

   localparam int PEND_AW = (PEND_DEPTH > 1) ? $clog2(PEND_DEPTH) : 1;
   localparam int ACT_AW = (ACT_DEPTH > 1) ? $clog2(ACT_DEPTH) : 1;

   localparam int CMD_W = 2;
   localparam int KEY_W = 32;
   localparam int PRIO_W = 8;
   localparam int GEN_W = 16;
   localparam int SEQ_W = 32;
   localparam int STATUS_W = 4;
   localparam int WORKERS_W = 3;

   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic [PRIO_W-1:0] prio;
      logic [SEQ_W-1:0]  seq;
   } pend_entry_type;

   localparam int ENTRY_W = $bits(pend_entry_type);

   localparam logic [CMD_W-1:0] CMD_REQUEST  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_TAKE     = 2'd1;
   localparam logic [CMD_W-1:0] CMD_COMPLETE = 2'd2;
   localparam logic [CMD_W-1:0] CMD_CLEAR    = 2'd3;

   localparam logic [STATUS_W-1:0] STS_QUEUED     = 4'd0;
   localparam logic [STATUS_W-1:0] STS_PROMOTED   = 4'd1;
   localparam logic [STATUS_W-1:0] STS_DUPLICATE  = 4'd2;
   localparam logic [STATUS_W-1:0] STS_STALE      = 4'd3;
   localparam logic [STATUS_W-1:0] STS_FULL       = 4'd4;
   localparam logic [STATUS_W-1:0] STS_DISPATCHED = 4'd5;
   localparam logic [STATUS_W-1:0] STS_EMPTY      = 4'd6;
   localparam logic [STATUS_W-1:0] STS_DELIVER    = 4'd7;
   localparam logic [STATUS_W-1:0] STS_DISCARD    = 4'd8;
   localparam logic [STATUS_W-1:0] STS_CLEARED    = 4'd9;

   localparam logic [WORKERS_W-1:0] WORKERS_RESET = 3'd2;

   typedef enum logic [1:0] {
      SCH_IDLE,
      SCH_SCAN,
      SCH_TAIL,
      SCH_DECIDE
   } state_type;

endpackage

`default_nettype wire

// ----- rtl/core/dpjs_intf.sv -----
`default_nettype none

interface dpjs_req_if import dpjs_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    cmd;
   logic [KEY_W-1:0]    job_key;
   logic [PRIO_W-1:0]   job_priority;
   logic [GEN_W-1:0]    job_generation;

   modport source (output valid, cmd, job_key, job_priority, job_generation, input ready);
   modport sink (input valid, cmd, job_key, job_priority, job_generation, output ready);
endinterface

interface dpjs_rsp_if import dpjs_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic                worker_grant;
   logic [KEY_W-1:0]    out_key;
   logic [PRIO_W-1:0]   out_priority;
   logic [GEN_W-1:0]    out_generation;

   modport source (output valid, status, worker_grant, out_key, out_priority, out_generation,
                   input ready);
   modport sink (input valid, status, worker_grant, out_key, out_priority, out_generation,
                 output ready);
endinterface

interface dpjs_csr_if import dpjs_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [WORKERS_W-1:0] max_workers;

   modport source (output valid, max_workers, input ready);
   modport sink (input valid, max_workers, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/dpjs_ram.sv -----
`default_nettype none

module dpjs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/core/dedup_priority_job_scheduler.sv -----
// Deduplicating priority job scheduler.
// Commands arrive as items on the req_ch channel (request, take next, complete,
// clear) and each one yields exactly one item on the rsp_ch channel. The worker
// limit is written through csr_ch, which is always ready, and must only be
// written while the block is idle.
// The pending table lives in a single-port-read, single-port-write RAM that is
// swept one entry per cycle. Request and take sweep every entry, pass through a
// tail state and then a decide state that writes the result register.
// Complete and clear skip the sweep and go straight to the decide state. A new
// item is accepted only once the block is back in idle after the last one.
// Results sit in an output register. A stalled receiver holds the result
// there while the next item is still accepted and swept; only the final
// update step waits for the register to drain.
// Reset clears the valid bits of both tables, the generation, the sequence
// counter and the worker count, and sets the worker limit to 2. No clearing
// pass over the RAM is needed.
`default_nettype none

module dedup_priority_job_scheduler import dpjs_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   dpjs_req_if.sink   req_ch,
   dpjs_rsp_if.source rsp_ch,
   dpjs_csr_if.sink   csr_ch
);

   state_type state_ff, state_in;

   logic [CMD_W-1:0]  cmd_ff;
   logic [KEY_W-1:0]  key_ff;
   logic [PRIO_W-1:0] prio_ff;
   logic [GEN_W-1:0]  gen_ff;

   logic [PEND_AW-1:0] scan_ff, scan_in;
   logic               rd_vld_ff, rd_vld_in;
   logic [PEND_AW-1:0] rd_idx_ff;

   logic               hit_ff, hit_in;
   logic [PEND_AW-1:0] hit_idx_ff, hit_idx_in;
   pend_entry_type     hit_entry_ff, hit_entry_in;
   logic               best_ff, best_in;
   logic [PEND_AW-1:0] best_idx_ff, best_idx_in;
   pend_entry_type     best_entry_ff, best_entry_in;

   logic [PEND_DEPTH-1:0] pend_valid_ff, pend_valid_in;
   logic [ACT_DEPTH-1:0]  act_valid_ff, act_valid_in;
   logic [KEY_W-1:0]      act_key_ff [ACT_DEPTH];
   logic [GEN_W-1:0]      cur_gen_ff, cur_gen_in;
   logic [SEQ_W-1:0]      seq_ff, seq_in;
   logic [WORKERS_W-1:0]  busy_ff, busy_in;
   logic [WORKERS_W-1:0]  max_workers_ff;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]  rsp_status_ff, status_d;
   logic                 rsp_start_ff, start_d;
   logic [KEY_W-1:0]     rsp_key_ff, okey_d;
   logic [PRIO_W-1:0]    rsp_prio_ff, oprio_d;
   logic [GEN_W-1:0]     rsp_gen_ff;

   logic req_ready, req_fire, out_free, decide_fire, scan_active, scan_last;
   logic act_wr;
   logic [ACT_AW-1:0] act_wr_idx;

   logic                ram_we;
   logic [PEND_AW-1:0]  ram_waddr;
   pend_entry_type      ram_wdata;
   logic [ENTRY_W-1:0]  ram_rdata;
   pend_entry_type      rd_entry;

   logic [KEY_W-1:0]     act_match_key;
   logic [ACT_DEPTH-1:0] act_eq;
   logic                 act_hit, act_free;
   logic [ACT_AW-1:0]    act_hit_idx, act_free_idx;
   logic                 pend_free;
   logic [PEND_AW-1:0]   pend_free_idx;
   logic [WORKERS_W-1:0] worker_lim;

   dpjs_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (PEND_DEPTH)
   ) u_pend_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (scan_ff),
      .rd_data (ram_rdata)
   );

   assign rd_entry = pend_entry_type'(ram_rdata);
   assign req_fire = req_ch.valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign scan_last = (scan_ff == PEND_AW'(PEND_DEPTH - 1));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         SCH_IDLE: begin
            if (req_fire) begin
               if (req_ch.cmd == CMD_REQUEST || req_ch.cmd == CMD_TAKE) begin
                  state_in = SCH_SCAN;
               end else begin
                  state_in = SCH_DECIDE;
               end
            end
         end
         SCH_SCAN: begin
            if (scan_last) begin
               state_in = SCH_TAIL;
            end
         end
         SCH_TAIL: begin
            state_in = SCH_DECIDE;
         end
         SCH_DECIDE: begin
            if (out_free) begin
               state_in = SCH_IDLE;
            end
         end
         default: begin
            state_in = SCH_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      scan_active = 1'b0;
      decide_fire = 1'b0;
      case (state_ff)
         SCH_IDLE: begin
            req_ready = 1'b1;
         end
         SCH_SCAN: begin
            scan_active = 1'b1;
         end
         SCH_TAIL: begin
            scan_active = 1'b0;
         end
         SCH_DECIDE: begin
            decide_fire = out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   assign scan_in = req_fire ? '0 : (scan_active ? scan_ff + 1'b1 : scan_ff);
   assign rd_vld_in = scan_active;

   always_comb begin
      hit_in = hit_ff;
      hit_idx_in = hit_idx_ff;
      hit_entry_in = hit_entry_ff;
      best_in = best_ff;
      best_idx_in = best_idx_ff;
      best_entry_in = best_entry_ff;
      if (req_fire) begin
         hit_in = 1'b0;
         best_in = 1'b0;
      end else if (rd_vld_ff && pend_valid_ff[rd_idx_ff]) begin
         if (!hit_ff && rd_entry.key == key_ff) begin
            hit_in = 1'b1;
            hit_idx_in = rd_idx_ff;
            hit_entry_in = rd_entry;
         end
         if (!best_ff || rd_entry.prio > best_entry_ff.prio ||
             (rd_entry.prio == best_entry_ff.prio && rd_entry.seq < best_entry_ff.seq)) begin
            best_in = 1'b1;
            best_idx_in = rd_idx_ff;
            best_entry_in = rd_entry;
         end
      end
   end

   assign act_match_key = (cmd_ff == CMD_TAKE) ? best_entry_ff.key : key_ff;

   always_comb begin
      act_hit = 1'b0;
      act_hit_idx = '0;
      act_free = 1'b0;
      act_free_idx = '0;
      for (int i = ACT_DEPTH - 1; i >= 0; i--) begin
         act_eq[i] = act_valid_ff[i] && (act_key_ff[i] == act_match_key);
         if (act_eq[i]) begin
            act_hit = 1'b1;
            act_hit_idx = ACT_AW'(i);
         end
         if (!act_valid_ff[i]) begin
            act_free = 1'b1;
            act_free_idx = ACT_AW'(i);
         end
      end
   end

   always_comb begin
      pend_free = 1'b0;
      pend_free_idx = '0;
      for (int i = PEND_DEPTH - 1; i >= 0; i--) begin
         if (!pend_valid_ff[i]) begin
            pend_free = 1'b1;
            pend_free_idx = PEND_AW'(i);
         end
      end
   end

   always_comb begin
      if (max_workers_ff == '0) begin
         worker_lim = WORKERS_W'(1);
      end else if (max_workers_ff > WORKERS_W'(WORKER_CAP)) begin
         worker_lim = WORKERS_W'(WORKER_CAP);
      end else begin
         worker_lim = max_workers_ff;
      end
   end

   always_comb begin
      pend_valid_in = pend_valid_ff;
      act_valid_in = act_valid_ff;
      act_wr = 1'b0;
      act_wr_idx = act_hit ? act_hit_idx : act_free_idx;
      ram_we = 1'b0;
      ram_waddr = hit_idx_ff;
      ram_wdata = hit_entry_ff;
      seq_in = seq_ff;
      busy_in = busy_ff;
      cur_gen_in = cur_gen_ff;
      status_d = STS_QUEUED;
      start_d = 1'b0;
      okey_d = '0;
      oprio_d = '0;
      if (decide_fire) begin
         case (cmd_ff)
            CMD_REQUEST: begin
               if (gen_ff != cur_gen_ff || act_hit) begin
                  status_d = STS_STALE;
               end else if (hit_ff) begin
                  if (prio_ff > hit_entry_ff.prio) begin
                     ram_we = 1'b1;
                     ram_waddr = hit_idx_ff;
                     ram_wdata = '{key: hit_entry_ff.key, prio: prio_ff, seq: hit_entry_ff.seq};
                     status_d = STS_PROMOTED;
                  end else begin
                     status_d = STS_DUPLICATE;
                  end
               end else if (!pend_free) begin
                  status_d = STS_FULL;
               end else begin
                  ram_we = 1'b1;
                  ram_waddr = pend_free_idx;
                  ram_wdata = '{key: key_ff, prio: prio_ff, seq: seq_ff};
                  pend_valid_in[pend_free_idx] = 1'b1;
                  seq_in = seq_ff + 1'b1;
                  status_d = STS_QUEUED;
                  if (busy_ff < worker_lim) begin
                     busy_in = busy_ff + 1'b1;
                     start_d = 1'b1;
                  end
               end
            end
            CMD_TAKE: begin
               if (!best_ff) begin
                  if (busy_ff != '0) begin
                     busy_in = busy_ff - 1'b1;
                  end
                  status_d = STS_EMPTY;
               end else if (!act_hit && !act_free) begin
                  status_d = STS_FULL;
               end else begin
                  act_wr = 1'b1;
                  act_valid_in[act_wr_idx] = 1'b1;
                  pend_valid_in[best_idx_ff] = 1'b0;
                  okey_d = best_entry_ff.key;
                  oprio_d = best_entry_ff.prio;
                  status_d = STS_DISPATCHED;
               end
            end
            CMD_COMPLETE: begin
               act_valid_in = act_valid_ff & ~act_eq;
               status_d = (gen_ff == cur_gen_ff) ? STS_DELIVER : STS_DISCARD;
            end
            default: begin
               cur_gen_in = cur_gen_ff + 1'b1;
               pend_valid_in = '0;
               act_valid_in = '0;
               status_d = STS_CLEARED;
            end
         endcase
      end
   end

   assign rsp_valid_in = decide_fire || (rsp_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SCH_IDLE;
         scan_ff <= '0;
         rd_vld_ff <= 1'b0;
         hit_ff <= 1'b0;
         best_ff <= 1'b0;
         pend_valid_ff <= '0;
         act_valid_ff <= '0;
         cur_gen_ff <= '0;
         seq_ff <= '0;
         busy_ff <= '0;
         max_workers_ff <= WORKERS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         scan_ff <= scan_in;
         rd_vld_ff <= rd_vld_in;
         hit_ff <= hit_in;
         best_ff <= best_in;
         pend_valid_ff <= pend_valid_in;
         act_valid_ff <= act_valid_in;
         cur_gen_ff <= cur_gen_in;
         seq_ff <= seq_in;
         busy_ff <= busy_in;
         if (csr_ch.valid) begin
            max_workers_ff <= csr_ch.max_workers;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= scan_ff;
      hit_idx_ff <= hit_idx_in;
      hit_entry_ff <= hit_entry_in;
      best_idx_ff <= best_idx_in;
      best_entry_ff <= best_entry_in;
      if (req_fire) begin
         cmd_ff <= req_ch.cmd;
         key_ff <= req_ch.job_key;
         prio_ff <= req_ch.job_priority;
         gen_ff <= req_ch.job_generation;
      end
      if (act_wr) begin
         act_key_ff[act_wr_idx] <= best_entry_ff.key;
      end
      if (decide_fire) begin
         rsp_status_ff <= status_d;
         rsp_start_ff <= start_d;
         rsp_key_ff <= okey_d;
         rsp_prio_ff <= oprio_d;
         rsp_gen_ff <= cur_gen_in;
      end
   end

   assign req_ch.ready = req_ready;
   assign csr_ch.ready = 1'b1;
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.status = rsp_status_ff;
   assign rsp_ch.worker_grant = rsp_start_ff;
   assign rsp_ch.out_key = rsp_key_ff;
   assign rsp_ch.out_priority = rsp_prio_ff;
   assign rsp_ch.out_generation = rsp_gen_ff;

endmodule

`default_nettype wire

// ----- rtl/core/dpjs_checker.sv -----
`default_nettype none

module dpjs_checker import dpjs_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [STATUS_W-1:0] status,
   input logic                worker_grant,
   input logic [KEY_W-1:0]    out_key,
   input logic [PRIO_W-1:0]   out_priority
);

   // A stalled result stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result item dropped while stalled");

   // Each command is processed alone, so the input closes right after an item.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input ready right after an accepted item");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> status <= STS_CLEARED)
      else $error("status code out of range");

   a_start_only_queued: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && worker_grant |-> status == STS_QUEUED)
      else $error("worker start without a queued request");

   a_payload_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status != STS_DISPATCHED |-> out_key == '0 && out_priority == '0)
      else $error("job payload on a result that dispatched nothing");

endmodule

bind dedup_priority_job_scheduler dpjs_checker u_dpjs_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_ch.valid),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .status       (rsp_ch.status),
   .worker_grant (rsp_ch.worker_grant),
   .out_key      (rsp_ch.out_key),
   .out_priority (rsp_ch.out_priority)
);

`default_nettype wire

// ----- bench/job_schedule_checker.sv -----
`timescale 1ns / 100ps

module job_schedule_checker import dpjs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   dpjs_req_if         req_mon,
   dpjs_rsp_if         rsp_mon,
   dpjs_csr_if         csr_mon,
   output int unsigned outstanding,
   output int unsigned failures
);

   localparam int MAX_REPORTS = 100;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                start;
      logic [KEY_W-1:0]    key;
      logic [PRIO_W-1:0]   prio;
      logic [GEN_W-1:0]    gen;
   } outcome_type;

   logic                 slot_live  [PEND_DEPTH];
   logic [KEY_W-1:0]     slot_key   [PEND_DEPTH];
   logic [PRIO_W-1:0]    slot_prio  [PEND_DEPTH];
   logic [SEQ_W-1:0]     slot_order [PEND_DEPTH];
   logic                 run_live   [ACT_DEPTH];
   logic [KEY_W-1:0]     run_key    [ACT_DEPTH];
   logic [GEN_W-1:0]     generation;
   logic [SEQ_W-1:0]     next_order;
   logic [WORKERS_W-1:0] workers_busy;
   logic [WORKERS_W-1:0] worker_cfg;

   outcome_type expected_outcomes [$];

   function automatic int find_run(input logic [KEY_W-1:0] key);
      int idx;
      idx = -1;
      for (int i = 0; i < ACT_DEPTH; i++)
         if (idx < 0 && run_live[i] && run_key[i] == key) idx = i;
      return idx;
   endfunction

   function automatic outcome_type apply_command(input logic [CMD_W-1:0] cmd,
                                                 input logic [KEY_W-1:0] key,
                                                 input logic [PRIO_W-1:0] prio,
                                                 input logic [GEN_W-1:0] gen);
      outcome_type res;
      int          hit;
      int          free_idx;
      int          sel;
      int          run_idx;
      int unsigned cap;
      res = '0;
      cap = (worker_cfg == 0) ? 1 : (worker_cfg > WORKER_CAP) ? WORKER_CAP : worker_cfg;
      case (cmd)
         CMD_REQUEST: begin
            if (gen != generation || find_run(key) >= 0) begin
               res.status = STS_STALE;
            end else begin
               hit = -1;
               for (int i = 0; i < PEND_DEPTH; i++)
                  if (hit < 0 && slot_live[i] && slot_key[i] == key) hit = i;
               if (hit >= 0) begin
                  if (prio > slot_prio[hit]) begin
                     slot_prio[hit] = prio;
                     res.status = STS_PROMOTED;
                  end else begin
                     res.status = STS_DUPLICATE;
                  end
               end else begin
                  free_idx = -1;
                  for (int i = 0; i < PEND_DEPTH; i++)
                     if (free_idx < 0 && !slot_live[i]) free_idx = i;
                  if (free_idx < 0) begin
                     res.status = STS_FULL;
                  end else begin
                     slot_live[free_idx] = 1'b1;
                     slot_key[free_idx] = key;
                     slot_prio[free_idx] = prio;
                     slot_order[free_idx] = next_order;
                     next_order = next_order + 1'b1;
                     res.status = STS_QUEUED;
                     if (workers_busy < cap) begin
                        workers_busy = workers_busy + 1'b1;
                        res.start = 1'b1;
                     end
                  end
               end
            end
         end
         CMD_TAKE: begin
            sel = -1;
            for (int i = 0; i < PEND_DEPTH; i++)
               if (slot_live[i] && (sel < 0 || slot_prio[i] > slot_prio[sel] ||
                   (slot_prio[i] == slot_prio[sel] && slot_order[i] < slot_order[sel])))
                  sel = i;
            if (sel < 0) begin
               if (workers_busy != 0) workers_busy = workers_busy - 1'b1;
               res.status = STS_EMPTY;
            end else begin
               run_idx = find_run(slot_key[sel]);
               for (int i = 0; i < ACT_DEPTH; i++)
                  if (run_idx < 0 && !run_live[i]) run_idx = i;
               if (run_idx < 0) begin
                  res.status = STS_FULL;
               end else begin
                  run_live[run_idx] = 1'b1;
                  run_key[run_idx] = slot_key[sel];
                  slot_live[sel] = 1'b0;
                  res.key = slot_key[sel];
                  res.prio = slot_prio[sel];
                  res.status = STS_DISPATCHED;
               end
            end
         end
         CMD_COMPLETE: begin
            for (int i = 0; i < ACT_DEPTH; i++)
               if (run_live[i] && run_key[i] == key) run_live[i] = 1'b0;
            res.status = (gen == generation) ? STS_DELIVER : STS_DISCARD;
         end
         default: begin
            generation = generation + 1'b1;
            for (int i = 0; i < PEND_DEPTH; i++) slot_live[i] = 1'b0;
            for (int i = 0; i < ACT_DEPTH; i++) run_live[i] = 1'b0;
            res.status = STS_CLEARED;
         end
      endcase
      res.gen = generation;
      return res;
   endfunction

   always @(posedge clock) begin
      outcome_type want;
      outcome_type got;
      if (reset) begin
         for (int i = 0; i < PEND_DEPTH; i++) slot_live[i] = 1'b0;
         for (int i = 0; i < ACT_DEPTH; i++) run_live[i] = 1'b0;
         generation = '0;
         next_order = '0;
         workers_busy = '0;
         worker_cfg = WORKERS_RESET;
         expected_outcomes.delete();
         outstanding <= 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.status = rsp_mon.status;
            got.start = rsp_mon.worker_grant;
            got.key = rsp_mon.out_key;
            got.prio = rsp_mon.out_priority;
            got.gen = rsp_mon.out_generation;
            if (expected_outcomes.size() == 0) begin
               failures <= failures + 1;
               if (failures < MAX_REPORTS)
                  $display("%0t: unexpected result status %0d start %0b key %h prio %0d gen %0d",
                           $time, got.status, got.start, got.key, got.prio, got.gen);
            end else begin
               want = expected_outcomes.pop_front();
               if (got.status !== want.status || got.start !== want.start ||
                   got.key !== want.key || got.prio !== want.prio || got.gen !== want.gen) begin
                  failures <= failures + 1;
                  if (failures < MAX_REPORTS) begin
                     $display("%0t: expected status %0d start %0b key %h prio %0d gen %0d",
                              $time, want.status, want.start, want.key, want.prio, want.gen);
                     $display("%0t:   actual status %0d start %0b key %h prio %0d gen %0d",
                              $time, got.status, got.start, got.key, got.prio, got.gen);
                  end
               end
            end
         end
         if (csr_mon.valid && csr_mon.ready) worker_cfg = csr_mon.max_workers;
         if (req_mon.valid && req_mon.ready)
            expected_outcomes.push_back(apply_command(req_mon.cmd, req_mon.job_key,
                                                      req_mon.job_priority,
                                                      req_mon.job_generation));
         outstanding <= expected_outcomes.size();
      end
   end

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 100ps

module tb import dpjs_pkg::*; ();

   localparam int POOL_SIZE      = 20;
   localparam int HOLD_AT        = 300;
   localparam int HOLD_CYCLES    = 400;
   localparam int PHASE_ITEMS    = 155;
   localparam int DRAIN_CYCLES   = 40;
   localparam int WATCHDOG_LIMIT = 3000;

   logic        clock;
   logic        reset;
   bit          no_gaps;
   int unsigned accepted_items;
   int unsigned outstanding;
   int unsigned failures;
   logic [GEN_W-1:0] generation;
   logic [KEY_W-1:0] key_pool [POOL_SIZE];
   logic [KEY_W-1:0] taken_keys [$];

   dpjs_req_if req_ch ();
   dpjs_rsp_if rsp_ch ();
   dpjs_csr_if csr_ch ();

   dedup_priority_job_scheduler i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   job_schedule_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_ch),
      .rsp_mon     (rsp_ch),
      .csr_mon     (csr_ch),
      .outstanding (outstanding),
      .failures    (failures)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready) accepted_items <= accepted_items + 1;
      if (!reset && rsp_ch.valid && rsp_ch.ready && rsp_ch.status == STS_DISPATCHED) begin
         taken_keys.push_back(rsp_ch.out_key);
         if (taken_keys.size() > 16) void'(taken_keys.pop_front());
      end
   end

   initial begin : receiver
      bit held;
      held = 1'b0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!held && accepted_items >= HOLD_AT) begin
            held = 1'b1;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
         end else if (!no_gaps && $urandom_range(0, 4) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(0, 7)) @(negedge clock);
         end else if ($urandom_range(0, 9) == 0) begin
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(10, 40)) @(negedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   initial begin : watchdog
      int unsigned idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

   task automatic send_job(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                           input logic [PRIO_W-1:0] prio, input logic [GEN_W-1:0] gen);
      if (!no_gaps && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.cmd <= cmd;
      req_ch.job_key <= key;
      req_ch.job_priority <= prio;
      req_ch.job_generation <= gen;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
      if (cmd == CMD_CLEAR) generation = generation + 1'b1;
   endtask

   task automatic write_limit(input logic [WORKERS_W-1:0] value);
      req_ch.valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.max_workers <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic random_item(input int mode);
      int               roll;
      int               req_share;
      int               take_share;
      int               idx;
      logic [CMD_W-1:0] cmd;
      logic [KEY_W-1:0] key;
      logic [PRIO_W-1:0] prio;
      logic [GEN_W-1:0] gen;
      req_share = (mode == 0) ? 65 : (mode == 1) ? 35 : 50;
      take_share = (mode == 0) ? 20 : (mode == 1) ? 45 : 30;
      roll = $urandom_range(0, 99);
      key = ($urandom_range(0, 9) == 0) ? KEY_W'($urandom()) :
            key_pool[$urandom_range(0, POOL_SIZE - 1)];
      if ($urandom_range(0, 7) == 0)
         prio = ($urandom_range(0, 1) == 0) ? '0 : '1;
      else
         prio = PRIO_W'($urandom_range(0, 255));
      gen = generation;
      if (roll < req_share) begin
         cmd = CMD_REQUEST;
         if ($urandom_range(0, 9) == 0) gen = GEN_W'($urandom());
      end else if (roll < req_share + take_share) begin
         cmd = CMD_TAKE;
      end else if (roll < 98) begin
         cmd = CMD_COMPLETE;
         if (taken_keys.size() != 0 && $urandom_range(0, 4) != 0) begin
            idx = $urandom_range(0, taken_keys.size() - 1);
            key = taken_keys[idx];
            taken_keys.delete(idx);
         end
         if ($urandom_range(0, 4) == 0)
            gen = ($urandom_range(0, 1) == 0) ? GEN_W'(generation - 1'b1) : GEN_W'($urandom());
      end else begin
         cmd = CMD_CLEAR;
      end
      send_job(cmd, key, prio, gen);
   endtask

   initial begin
      logic [WORKERS_W-1:0] limits [7];
      limits = '{3'd1, 3'd4, 3'd0, 3'd7, 3'd3, 3'd5, 3'd2};
      no_gaps = 1'b0;
      generation = '0;
      key_pool[0] = '0;
      key_pool[1] = '1;
      for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = KEY_W'($urandom());
      req_ch.valid = 1'b0;
      req_ch.cmd = CMD_REQUEST;
      req_ch.job_key = '0;
      req_ch.job_priority = '0;
      req_ch.job_generation = '0;
      csr_ch.valid = 1'b0;
      csr_ch.max_workers = WORKERS_RESET;
      reset = 1'b1;
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      send_job(CMD_TAKE, 32'h0, 8'h00, 16'h0000);
      send_job(CMD_REQUEST, 32'h0, 8'h00, 16'h0000);
      send_job(CMD_REQUEST, 32'hFFFF_FFFF, 8'hFF, 16'h0000);
      send_job(CMD_REQUEST, 32'h0, 8'h00, 16'h0000);
      send_job(CMD_REQUEST, 32'h0, 8'd10, 16'h0000);
      send_job(CMD_REQUEST, 32'h5, 8'd10, 16'h0000);
      send_job(CMD_REQUEST, 32'h7, 8'd20, 16'hFFFF);
      send_job(CMD_TAKE, 32'h0, 8'h00, 16'h0000);
      send_job(CMD_REQUEST, 32'hFFFF_FFFF, 8'd1, 16'h0000);
      send_job(CMD_TAKE, 32'h0, 8'h00, 16'h0000);
      send_job(CMD_TAKE, 32'h0, 8'h00, 16'h0000);
      send_job(CMD_TAKE, 32'h0, 8'h00, 16'h0000);
      send_job(CMD_COMPLETE, 32'h0, 8'h00, 16'h0000);
      send_job(CMD_COMPLETE, 32'h0, 8'h00, 16'h0000);
      send_job(CMD_COMPLETE, 32'h1234, 8'h00, 16'hFFFF);
      send_job(CMD_REQUEST, 32'd10, 8'd3, 16'h0000);
      send_job(CMD_REQUEST, 32'd11, 8'd3, 16'h0000);
      send_job(CMD_REQUEST, 32'd12, 8'd3, 16'h0000);
      send_job(CMD_TAKE, 32'h0, 8'h00, 16'h0000);
      send_job(CMD_TAKE, 32'h0, 8'h00, 16'h0000);
      send_job(CMD_TAKE, 32'h0, 8'h00, 16'h0000);
      send_job(CMD_CLEAR, 32'h0, 8'h00, 16'h0000);
      send_job(CMD_REQUEST, 32'h0, 8'd5, 16'h0000);

      for (int ph = 0; ph < 7; ph++) begin
         write_limit(limits[ph]);
         if (ph == 6) no_gaps = 1'b1;
         repeat (PHASE_ITEMS) random_item(ph % 3);
      end

      req_ch.valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (failures == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
